### hdl/mm2h_pkg.sv
package mm2h_pkg;

	typedef logic [31:0] word_t;
	typedef logic [2:0]  count_t;

	localparam word_t       MIX_MUL     = 32'h5bd1e995;
	localparam int unsigned WORD_SHIFT  = 24;
	localparam int unsigned FIN_SHIFT_A = 13;
	localparam int unsigned FIN_SHIFT_B = 15;

	// Keeps the valid bytes of a short tail; only counts 1 to 3 reach here.
	function automatic word_t tail_mask(input count_t n);
		word_t m;
		begin
			case (n)
				3'd1:    m = 32'h0000_00ff;
				3'd2:    m = 32'h0000_ffff;
				default: m = 32'h00ff_ffff;
			endcase
			return m;
		end
	endfunction

	// Only the low 32 bits of the product are kept.
	function automatic word_t mul_m(input word_t a);
		begin
			return a * MIX_MUL;
		end
	endfunction

endpackage

### hdl/mm2h_ifs.sv
interface mm2h_in_if;
	logic              valid;
	logic              ready;
	mm2h_pkg::word_t   data_word;
	mm2h_pkg::count_t  byte_count;
	logic              first;
	logic              last;
	mm2h_pkg::word_t   message_length;

	modport source (output valid, output data_word, output byte_count, output first,
		output last, output message_length, input ready);
	modport sink (input valid, input data_word, input byte_count, input first,
		input last, input message_length, output ready);
endinterface

interface mm2h_out_if;
	logic            valid;
	logic            ready;
	mm2h_pkg::word_t hash;

	modport source (output valid, output hash, input ready);
	modport sink (input valid, input hash, output ready);
endinterface

### hdl/murmur2_hash32_unit.sv
// Channel   Direction  Payload
// msg       in         data_word[31:0], byte_count[2:0], first, last, message_length[31:0]
// result    out        hash[31:0]
// cfg       in         cfg_we, cfg_wdata[31:0] (seed)
//
// A full word takes the accept step and three passes through the one
// 32x32 multiplier by the constant, which is the single arithmetic unit here.
// A short tail takes the accept step and one pass, an empty item only the accept step;
// a last item adds the final mix and output step. Reset zeroes the seed and running hash.
// A finished hash waits in the output register, and the next transaction is
// taken meanwhile; only a second hash stalls until the first is taken.
module murmur2_hash32_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  mm2h_pkg::word_t     cfg_wdata,
	mm2h_in_if.sink             msg,
	mm2h_out_if.source          result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_K1   = 3'd1;
	localparam logic [2:0] S_K2   = 3'd2;
	localparam logic [2:0] S_HM   = 3'd3;
	localparam logic [2:0] S_TAIL = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]      state_q;
	mm2h_pkg::word_t seed_q;
	mm2h_pkg::word_t h_q;
	mm2h_pkg::word_t k_q;
	logic            last_q;
	logic            res_valid_q;
	mm2h_pkg::word_t res_hash_q;

	mm2h_pkg::word_t mul_a;
	mm2h_pkg::word_t mul_p;
	mm2h_pkg::word_t h_init;
	logic            accept;

	assign msg.ready    = (state_q == S_IDLE);
	assign accept       = msg.valid && msg.ready;
	assign result.valid = res_valid_q;
	assign result.hash  = res_hash_q;

	assign h_init = msg.first ? (seed_q ^ msg.message_length) : h_q;

	// Operand select for the shared multiplier.
	always_comb begin
		case (state_q)
			S_K1:    mul_a = k_q;
			S_K2:    mul_a = k_q ^ (k_q >> mm2h_pkg::WORD_SHIFT);
			S_HM:    mul_a = h_q;
			S_TAIL:  mul_a = h_q;
			S_FIN:   mul_a = h_q ^ (h_q >> mm2h_pkg::FIN_SHIFT_A);
			default: mul_a = k_q;
		endcase
	end

	assign mul_p = mm2h_pkg::mul_m(mul_a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_we) begin
			seed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			h_q         <= '0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= msg.last;
						if (msg.byte_count[2]) begin
							h_q     <= h_init;
							state_q <= S_K1;
						end else if (msg.byte_count != 3'd0) begin
							h_q     <= h_init ^ (msg.data_word &
								mm2h_pkg::tail_mask(msg.byte_count));
							state_q <= S_TAIL;
						end else begin
							h_q     <= h_init;
							state_q <= msg.last ? S_FIN : S_IDLE;
						end
					end
				end
				S_K1: begin
					state_q <= S_K2;
				end
				S_K2: begin
					state_q <= S_HM;
				end
				S_HM: begin
					h_q     <= mul_p ^ k_q;
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_TAIL: begin
					h_q     <= mul_p;
					state_q <= last_q ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The word scratch register also holds the final mix so that h_q keeps
	// the running hash from before it.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			k_q <= msg.data_word;
		end else if (state_q == S_K1 || state_q == S_K2 || state_q == S_FIN) begin
			k_q <= mul_p;
		end
		if (state_q == S_OUT && (!res_valid_q || result.ready)) begin
			res_hash_q <= k_q ^ (k_q >> mm2h_pkg::FIN_SHIFT_B);
		end
	end

	a_full_word_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && msg.byte_count[2]) |=> (state_q == S_K1))
		else $error("full word did not start the multiply sequence");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside the output step");

	a_empty_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && msg.byte_count == 3'd0 && !msg.last) |=> (state_q == S_IDLE))
		else $error("empty item did not return to idle");

	a_fin_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HM && last_q) |=> (state_q == S_FIN))
		else $error("last word skipped the final mix");

endmodule
